// ----- sv/ctcgd_pkg.sv -----
// Shared types and constants for the greedy CTC decoder.
`default_nettype none

package ctcgd_pkg;

	localparam int CLASS_W = 6;
	localparam int PROB_W  = 17;
	localparam int COUNT_W = 6;

	localparam logic [PROB_W-1:0] ONE_Q16 = 17'h10000;
	localparam logic [CLASS_W-1:0] BLANK  = '0;

	localparam int NUM_CLASSES_DEF = 64;
	localparam int MAX_STEPS_DEF   = 32;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	// Work handed from the front end to the back end.
	typedef struct packed {
		logic               new_char;
		logic [CLASS_W-1:0] char_index;
		logic [PROB_W-1:0]  prob;
		logic [PROB_W-1:0]  best;
		logic               last;
	} op_t;

	// Queue status seen by the back end.
	typedef struct packed {
		logic valid;
	} qctl_t;

endpackage

`default_nettype wire

// ----- sv/ctc_greedy_decode.sv -----
// A timestep that adds a character or ends the sequence is queued; its result is
// registered when the back end loads it. Input: one timestep per cycle unless
// in_stall; a final character timestep gives two results, character then verdict.
// The back end does one 17x17 multiply per character; a two-entry queue decouples it.
// Reset: previous class blank, score one (Q1.16), count zero, queue and output empty.
`default_nettype none

module ctc_greedy_decode #(
	parameter int NUM_CLASSES = ctcgd_pkg::NUM_CLASSES_DEF,
	parameter int MAX_STEPS   = ctcgd_pkg::MAX_STEPS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output      logic                          in_stall,
	input  wire logic [ctcgd_pkg::CLASS_W-1:0] class_id,
	input  wire logic [ctcgd_pkg::PROB_W-1:0]  prob,
	input  wire logic [ctcgd_pkg::PROB_W-1:0]  prev_best_conf,
	input  wire logic                          last_step,
	output      logic                          out_valid,
	input  wire logic                          out_stall,
	output      logic                          is_char,
	output      logic [ctcgd_pkg::CLASS_W-1:0] char_index,
	output      logic [ctcgd_pkg::COUNT_W-1:0] char_count,
	output      logic [ctcgd_pkg::PROB_W-1:0]  score,
	output      logic                          better,
	output      logic                          done_res
);

	logic              q_full;
	logic              q_push;
	logic              q_pop;
	ctcgd_pkg::op_t    q_op;
	ctcgd_pkg::op_t    head_op;
	ctcgd_pkg::qctl_t  head_ctl;

	ctcgd_front #(
		.NUM_CLASSES(NUM_CLASSES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.class_id      (class_id),
		.prob          (prob),
		.prev_best_conf(prev_best_conf),
		.last_step     (last_step),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_op          (q_op)
	);

	ctcgd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_op (q_op),
		.full    (q_full),
		.pop     (q_pop),
		.head_ctl(head_ctl),
		.head_op (head_op)
	);

	ctcgd_back #(
		.MAX_STEPS(MAX_STEPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_ctl  (head_ctl),
		.head_op   (head_op),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.is_char   (is_char),
		.char_index(char_index),
		.char_count(char_count),
		.score     (score),
		.better    (better),
		.done_res  (done_res)
	);

endmodule

`default_nettype wire

// ----- sv/ctcgd_front.sv -----
// Front end: takes timesteps, collapses repeats, drops blanks, queues work.
`default_nettype none

module ctcgd_front #(
	parameter int NUM_CLASSES = ctcgd_pkg::NUM_CLASSES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output      logic                         in_stall,
	input  wire logic [ctcgd_pkg::CLASS_W-1:0] class_id,
	input  wire logic [ctcgd_pkg::PROB_W-1:0]  prob,
	input  wire logic [ctcgd_pkg::PROB_W-1:0]  prev_best_conf,
	input  wire logic                         last_step,
	input  wire logic                         q_full,
	output      logic                         q_push,
	output      ctcgd_pkg::op_t               q_op
);

	logic [ctcgd_pkg::CLASS_W-1:0] prev_class_q;
	logic [ctcgd_pkg::CLASS_W-1:0] cls;
	logic                          new_char;
	logic                          accept;

	always_comb begin
		// Treat a class beyond the alphabet as a blank.
		if (int'(class_id) >= NUM_CLASSES) begin
			cls = ctcgd_pkg::BLANK;
		end else begin
			cls = class_id;
		end
		new_char = (cls != ctcgd_pkg::BLANK) && (cls != prev_class_q);
	end

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign q_push   = accept && (new_char || last_step);

	always_comb begin
		q_op.new_char   = new_char;
		q_op.char_index = cls - ctcgd_pkg::CLASS_W'(1);
		q_op.prob       = (prob > ctcgd_pkg::ONE_Q16) ? ctcgd_pkg::ONE_Q16 : prob;
		q_op.best       = prev_best_conf;
		q_op.last       = last_step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_class_q <= ctcgd_pkg::BLANK;
		end else if (accept) begin
			prev_class_q <= last_step ? ctcgd_pkg::BLANK : cls;
		end
	end

endmodule

`default_nettype wire

// ----- sv/ctcgd_fifo.sv -----
// Two-entry work queue between front and back ends.
`default_nettype none

module ctcgd_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire ctcgd_pkg::op_t    push_op,
	output      logic              full,
	input  wire logic              pop,
	output      ctcgd_pkg::qctl_t  head_ctl,
	output      ctcgd_pkg::op_t    head_op
);

	ctcgd_pkg::op_t                   mem_q [ctcgd_pkg::QDEPTH];
	logic [ctcgd_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [ctcgd_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [ctcgd_pkg::QCNT_W-1:0]     count_q;
	logic                             do_push;
	logic                             do_pop;

	assign full           = (count_q == ctcgd_pkg::QCNT_W'(ctcgd_pkg::QDEPTH));
	assign head_ctl.valid = (count_q != '0);
	assign head_op        = mem_q[rd_ptr_q];
	assign do_push        = push && !full;
	assign do_pop         = pop && head_ctl.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + ctcgd_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + ctcgd_pkg::QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + ctcgd_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - ctcgd_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- sv/ctcgd_back.sv -----
// Back end: scores characters, counts them and issues the end-of-sequence verdict.
`default_nettype none

module ctcgd_back #(
	parameter int MAX_STEPS = ctcgd_pkg::MAX_STEPS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ctcgd_pkg::qctl_t              head_ctl,
	input  wire ctcgd_pkg::op_t                head_op,
	output      logic                          pop,
	output      logic                          out_valid,
	input  wire logic                          out_stall,
	output      logic                          is_char,
	output      logic [ctcgd_pkg::CLASS_W-1:0] char_index,
	output      logic [ctcgd_pkg::COUNT_W-1:0] char_count,
	output      logic [ctcgd_pkg::PROB_W-1:0]  score,
	output      logic                          better,
	output      logic                          done_res
);

	localparam int CountCap = (MAX_STEPS < 63) ? MAX_STEPS : 63;
	localparam int ProdW    = 2 * ctcgd_pkg::PROB_W;

	logic [ctcgd_pkg::PROB_W-1:0]  run_score_q;
	logic [ctcgd_pkg::COUNT_W-1:0] emitted_q;
	logic                          verdict_pend_q;
	logic                          out_valid_q;
	logic                          is_char_q;
	logic [ctcgd_pkg::CLASS_W-1:0] char_index_q;
	logic [ctcgd_pkg::COUNT_W-1:0] char_count_q;
	logic [ctcgd_pkg::PROB_W-1:0]  score_q;
	logic                          better_q;
	logic                          done_res_q;

	logic                          load;
	logic                          do_char;
	logic [ProdW-1:0]              prod;
	logic [ctcgd_pkg::PROB_W-1:0]  new_score;
	logic [ctcgd_pkg::COUNT_W-1:0] new_count;

	assign load    = head_ctl.valid && (!out_valid_q || !out_stall);
	assign do_char = head_op.new_char && !verdict_pend_q;
	// Hold the entry while its verdict is still owed.
	assign pop     = load && !(do_char && head_op.last);

	always_comb begin
		prod      = ProdW'(run_score_q) * ProdW'(head_op.prob);
		new_score = prod[ctcgd_pkg::PROB_W+15:16];
		if (emitted_q < ctcgd_pkg::COUNT_W'(CountCap)) begin
			new_count = emitted_q + ctcgd_pkg::COUNT_W'(1);
		end else begin
			new_count = emitted_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_score_q    <= ctcgd_pkg::ONE_Q16;
			emitted_q      <= '0;
			verdict_pend_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				if (do_char) begin
					run_score_q    <= new_score;
					emitted_q      <= new_count;
					verdict_pend_q <= head_op.last;
				end else begin
					run_score_q    <= ctcgd_pkg::ONE_Q16;
					emitted_q      <= '0;
					verdict_pend_q <= 1'b0;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (do_char) begin
				is_char_q    <= 1'b1;
				char_index_q <= head_op.char_index;
				char_count_q <= new_count;
				score_q      <= new_score;
				better_q     <= 1'b0;
				done_res_q   <= 1'b0;
			end else begin
				is_char_q    <= 1'b0;
				char_index_q <= '0;
				char_count_q <= emitted_q;
				score_q      <= run_score_q;
				better_q     <= (run_score_q > head_op.best);
				done_res_q   <= 1'b1;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign is_char    = is_char_q;
	assign char_index = char_index_q;
	assign char_count = char_count_q;
	assign score      = score_q;
	assign better     = better_q;
	assign done_res   = done_res_q;

endmodule

`default_nettype wire
